// ===== design/clscan_pkg.sv =====
package clscan_pkg;

  localparam int unsigned COLUMN_BITS_DEFAULT = 16;

  // Widths of the fields on the result side, fixed whatever the column width.
  localparam int unsigned OUT_COL_BITS = 16;
  localparam int unsigned OUT_DATA_BITS = 48;

  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_VT        = 8'h0B;
  localparam logic [7:0] CHAR_FF        = 8'h0C;
  localparam logic [7:0] CHAR_NEL       = 8'h85;
  localparam logic [7:0] CHAR_NBSP      = 8'hA0;
  localparam logic [7:0] CHAR_NUL       = 8'h00;

  localparam logic [1:0] KIND_NORMAL    = 2'd0;
  localparam logic [1:0] KIND_BLOCK     = 2'd1;
  localparam logic [1:0] KIND_CONTINUED = 2'd2;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF) ||
           (b == CHAR_NEL) || (b == CHAR_NBSP) || (b == CHAR_NUL);
  endfunction

endpackage

// ===== design/comment_aware_line_scanner_unit.sv =====
// Line scanner for C source text. One byte enters per cycle on the slave side and
// every line end (LF, CR, CR LF counted once, or the tlast byte) yields one word on
// the master side in the next cycle, giving the line length, the first column and
// character outside comments and whitespace, and whether the line ends inside a
// block comment or in a backslash-continued line comment. The sustained rate is one
// byte per clock: the comment flags and column counters update with each accepted
// byte, and a new byte may enter in the same cycle as a waiting line word is taken;
// while a line word waits and the master side is not ready, the slave side holds
// tready low. All scanning state returns to its reset value after the byte flagged
// by tlast. Column counts saturate at 2^COLUMN_BITS - 1 and are reported in 16 bits.
module comment_aware_line_scanner_unit #(
  parameter int unsigned COLUMN_BITS = clscan_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // text_byte[7:0]
  input  logic [7:0]                           s_axis_tdata,
  // final_byte
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // line_length[15:0], first_text_column[31:16], has_text[32],
  // first_text_char[40:33], zero padding[47:41]
  output logic [clscan_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  // line_kind[1:0]
  output logic [1:0]                           m_axis_tuser
);
  import clscan_pkg::*;

  localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = {COLUMN_BITS{1'b1}};

  logic                   in_block_q, in_block_d;
  logic                   in_line_q, in_line_d;
  logic                   held_slash_q, held_slash_d;
  logic                   held_star_q, held_star_d;
  logic                   after_cr_q, after_cr_d;
  logic                   last_bs_q, last_bs_d;
  logic [COLUMN_BITS-1:0] col_count_q, col_count_d;
  logic [COLUMN_BITS-1:0] first_col_q, first_col_d;
  logic [7:0]             first_char_q, first_char_d;

  logic                   out_valid_q;
  logic [1:0]             out_kind_q, out_kind_d;
  logic [OUT_COL_BITS-1:0] out_len_q, out_len_d;
  logic [OUT_COL_BITS-1:0] out_first_q, out_first_d;
  logic                   out_has_q, out_has_d;
  logic [7:0]             out_char_q, out_char_d;
  logic                   emit;

  logic accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  function automatic logic [OUT_COL_BITS-1:0] to_out(input logic [COLUMN_BITS-1:0] v);
    logic [COLUMN_BITS+OUT_COL_BITS-1:0] ext;
    ext = {{OUT_COL_BITS{1'b0}}, v};
    return ext[OUT_COL_BITS-1:0];
  endfunction

  always_comb begin
    logic [7:0]             b;
    logic                   swallow;
    logic                   term;
    logic [COLUMN_BITS-1:0] col;
    logic [COLUMN_BITS-1:0] col_prev;
    logic                   consumed;
    logic [1:0]             kind;

    b       = s_axis_tdata;
    swallow = after_cr_q && (b == CHAR_LF);
    term    = (b == CHAR_LF) || (b == CHAR_CR);

    in_block_d   = in_block_q;
    in_line_d    = in_line_q;
    held_slash_d = held_slash_q;
    held_star_d  = held_star_q;
    last_bs_d    = last_bs_q;
    col_count_d  = col_count_q;
    first_col_d  = first_col_q;
    first_char_d = first_char_q;
    after_cr_d   = 1'b0;
    emit         = 1'b0;
    kind         = KIND_NORMAL;
    consumed     = 1'b0;
    col          = col_count_q;
    col_prev     = (col_count_q == '0) ? '0 : col_count_q - 1'b1;

    // Ordinary character: comment tracking and column bookkeeping.
    if (!swallow && !term) begin
      if (col_count_q != COLUMN_MAX) begin
        col_count_d = col_count_q + 1'b1;
      end
      last_bs_d = (b == CHAR_BACKSLASH);
      if (in_block_q) begin
        if (held_star_q && (b == CHAR_SLASH)) begin
          in_block_d  = 1'b0;
          held_star_d = 1'b0;
        end else begin
          held_star_d = (b == CHAR_STAR);
        end
      end else if (!in_line_q) begin
        if (held_slash_q) begin
          held_slash_d = 1'b0;
          if (b == CHAR_STAR) begin
            in_block_d  = 1'b1;
            held_star_d = 1'b0;
            consumed    = 1'b1;
          end else if (b == CHAR_SLASH) begin
            in_line_d = 1'b1;
            consumed  = 1'b1;
          end else if (first_char_d == CHAR_NUL) begin
            // The held slash turns out to be text one column back.
            first_char_d = CHAR_SLASH;
            first_col_d  = col_prev;
          end
        end
        if (!consumed) begin
          if (b == CHAR_SLASH) begin
            held_slash_d = 1'b1;
          end else if ((first_char_d == CHAR_NUL) && !is_blank(b)) begin
            first_char_d = b;
            first_col_d  = col;
          end
        end
      end
    end

    // Line end, either from a terminator or from the last byte of the text.
    if (!swallow && (term || s_axis_tlast)) begin
      emit = 1'b1;
      if (held_slash_d && (first_char_d == CHAR_NUL)) begin
        first_char_d = CHAR_SLASH;
        first_col_d  = (col_count_d == '0) ? '0 : col_count_d - 1'b1;
      end
      if (in_block_d) begin
        kind = KIND_BLOCK;
      end else if (in_line_d && last_bs_d) begin
        kind = KIND_CONTINUED;
      end else begin
        kind = KIND_NORMAL;
      end
      out_kind_d  = kind;
      out_len_d   = to_out(col_count_d);
      out_first_d = (first_char_d != CHAR_NUL) ? to_out(first_col_d) : to_out(col_count_d);
      out_has_d   = (first_char_d != CHAR_NUL);
      out_char_d  = first_char_d;

      in_line_d    = (kind == KIND_CONTINUED);
      col_count_d  = '0;
      first_col_d  = COLUMN_MAX;
      first_char_d = CHAR_NUL;
      last_bs_d    = 1'b0;
      held_slash_d = 1'b0;
      held_star_d  = 1'b0;
      after_cr_d   = (b == CHAR_CR);
    end else begin
      out_kind_d  = out_kind_q;
      out_len_d   = out_len_q;
      out_first_d = out_first_q;
      out_has_d   = out_has_q;
      out_char_d  = out_char_q;
    end

    if (s_axis_tlast) begin
      in_block_d   = 1'b0;
      in_line_d    = 1'b0;
      after_cr_d   = 1'b0;
      col_count_d  = '0;
      first_col_d  = COLUMN_MAX;
      first_char_d = CHAR_NUL;
      last_bs_d    = 1'b0;
      held_slash_d = 1'b0;
      held_star_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_block_q   <= 1'b0;
      in_line_q    <= 1'b0;
      held_slash_q <= 1'b0;
      held_star_q  <= 1'b0;
      after_cr_q   <= 1'b0;
      last_bs_q    <= 1'b0;
      col_count_q  <= '0;
      first_col_q  <= COLUMN_MAX;
      first_char_q <= CHAR_NUL;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        in_block_q   <= in_block_d;
        in_line_q    <= in_line_d;
        held_slash_q <= held_slash_d;
        held_star_q  <= held_star_d;
        after_cr_q   <= after_cr_d;
        last_bs_q    <= last_bs_d;
        col_count_q  <= col_count_d;
        first_col_q  <= first_col_d;
        first_char_q <= first_char_d;
      end
      // The result register drains on a taken word and refills on an emitting byte.
      if (accept) begin
        out_valid_q <= emit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_kind_q  <= out_kind_d;
      out_len_q   <= out_len_d;
      out_first_q <= out_first_d;
      out_has_q   <= out_has_d;
      out_char_q  <= out_char_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - 2*OUT_COL_BITS - 9){1'b0}},
                          out_char_q, out_has_q, out_first_q, out_len_q};

endmodule
